// ===== rtl/core/tetrahedron_circumcenter_assert.svh =====
// ----------------------------------------------------------------------------
// tetrahedron circumcenter assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef TETRAHEDRON_CIRCUMCENTER_ASSERT_SVH
`define TETRAHEDRON_CIRCUMCENTER_ASSERT_SVH

// check under reset masking
`define TCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs during reset
`define TCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// shared constants and types of the tetrahedron circumcenter pipeline
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
    logic [2:0] ovf;
  } tcc_flags_t;

endpackage

// ===== rtl/core/tcc_geom.sv =====
// ----------------------------------------------------------------------------
// tcc_geom
// six stage front end: edge vectors, squared lengths, cross products,
// split partial products, exact numerator and doubled determinant
// ----------------------------------------------------------------------------
module tcc_geom #(
  parameter int W = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [W-1:0]      a_in [3],
  input  logic signed [W-1:0]      p_in [3][3],
  output logic                     out_valid,
  output logic signed [W-1:0]      a_out [3],
  output logic signed [2*(W+1)+1+2*(W+1)+1+2-1:0] num_out [3],
  output logic signed [(W+1)+2*(W+1)+1+3-1:0]     den_out
);
  localparam int EW  = W + 1;
  localparam int PW  = 2 * EW;
  localparam int LW  = 2 * EW + 1;
  localparam int CW  = 2 * EW + 1;
  localparam int NTW = LW + CW;
  localparam int NUW = NTW + 2;
  localparam int DPW = EW + CW;
  localparam int DW  = EW + CW + 3;
  localparam int HB  = (LW + 1) / 2;
  localparam int PPW = 2 * HB + 1;

  logic [5:0] v;

  logic signed [W-1:0]   a1 [3], a2 [3], a3 [3], a4 [3], a5 [3], a6 [3];
  logic signed [EW-1:0]  e1 [3][3];
  logic signed [EW-1:0]  e0_2 [3], e0_3 [3];
  logic signed [PW-1:0]  sq2 [3][3];
  logic signed [PW-1:0]  pm2 [3][3][2];
  logic signed [LW-1:0]  lsq3 [3];
  logic signed [CW-1:0]  cr3 [3][3];
  logic signed [PPW-1:0] pp4 [3][3][4];
  logic signed [PPW-1:0] dq4 [3][2];
  logic signed [NTW-1:0] nt5 [3][3];
  logic signed [DPW-1:0] dp5 [3];
  logic signed [NUW-1:0] num6 [3];
  logic signed [DW-1:0]  den6;
  logic signed [DW-1:0]  dsum;

  // operand pairs of the three cross products
  localparam int U_IDX [3] = '{0, 2, 1};
  localparam int V_IDX [3] = '{1, 0, 2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  assign dsum = DW'(dp5[0]) + DW'(dp5[1]) + DW'(dp5[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_in;
      a2 <= a1;
      a3 <= a2;
      a4 <= a3;
      a5 <= a4;
      a6 <= a5;
      e0_2 <= e1[0];
      e0_3 <= e0_2;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e1[i][k] <= $signed({p_in[i][k][W-1], p_in[i][k]})
                    - $signed({a_in[k][W-1], a_in[k]});
          sq2[i][k] <= PW'(e1[i][k]) * PW'(e1[i][k]);
        end
        lsq3[i] <= LW'(sq2[i][0]) + LW'(sq2[i][1]) + LW'(sq2[i][2]);
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pm2[j][k][0] <= PW'(e1[U_IDX[j]][(k+1)%3]) * PW'(e1[V_IDX[j]][(k+2)%3]);
          pm2[j][k][1] <= PW'(e1[U_IDX[j]][(k+2)%3]) * PW'(e1[V_IDX[j]][(k+1)%3]);
          cr3[j][k] <= CW'(pm2[j][k][0]) - CW'(pm2[j][k][1]);
          // high and low halves of length times cross component
          pp4[k][j][0] <= PPW'($signed(lsq3[2-j][LW-1:HB]))
                        * PPW'($signed(cr3[j][k][CW-1:HB]));
          pp4[k][j][1] <= PPW'($signed(lsq3[2-j][LW-1:HB]))
                        * PPW'($signed({1'b0, cr3[j][k][HB-1:0]}));
          pp4[k][j][2] <= PPW'($signed({1'b0, lsq3[2-j][HB-1:0]}))
                        * PPW'($signed(cr3[j][k][CW-1:HB]));
          pp4[k][j][3] <= PPW'($signed({1'b0, lsq3[2-j][HB-1:0]}))
                        * PPW'($signed({1'b0, cr3[j][k][HB-1:0]}));
          nt5[k][j] <= (NTW'(pp4[k][j][0]) <<< (2 * HB))
                     + (NTW'(pp4[k][j][1]) <<< HB)
                     + (NTW'(pp4[k][j][2]) <<< HB)
                     + NTW'(pp4[k][j][3]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        dq4[k][0] <= PPW'(e0_3[k]) * PPW'($signed(cr3[2][k][CW-1:HB]));
        dq4[k][1] <= PPW'(e0_3[k]) * PPW'($signed({1'b0, cr3[2][k][HB-1:0]}));
        dp5[k]    <= (DPW'(dq4[k][0]) <<< HB) + DPW'(dq4[k][1]);
        num6[k]   <= NUW'(nt5[k][0]) + NUW'(nt5[k][1]) + NUW'(nt5[k][2]);
      end
      den6 <= dsum + dsum;
    end
  end

  assign out_valid = v[5];
  assign a_out     = a6;
  assign num_out   = num6;
  assign den_out   = den6;

endmodule

// ===== rtl/core/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, with overflow and zero divisor detection up front
// ----------------------------------------------------------------------------
module tcc_div #(
  parameter int W = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [W-1:0]    a_in [3],
  input  logic signed [2*(W+1)+1+2*(W+1)+1+2-1:0] num_in [3],
  input  logic signed [(W+1)+2*(W+1)+1+3-1:0]     den_in,
  output logic                   out_valid,
  output logic signed [W-1:0]    a_out [3],
  output logic [W+1:0]           q_out [3],
  output tcc_pkg::tcc_flags_t    flags_out
);
  localparam int EW  = W + 1;
  localparam int NUW = 4 * EW + 4;
  localparam int DW  = 3 * EW + 4;
  localparam int QB  = W + 2;
  localparam int XW  = NUW + QB;

  logic [QB:0]           v;
  logic [NUW-1:0]        r_st  [QB+1][3];
  logic [QB-1:0]         q_st  [QB+1][3];
  logic [DW-1:0]         dd_st [QB+1];
  logic signed [W-1:0]   a_st  [QB+1][3];
  tcc_pkg::tcc_flags_t   f_st  [QB+1];

  logic [DW-1:0]         dd_abs;
  logic [NUW-1:0]        n_abs [3];

  always_comb begin
    dd_abs = den_in[DW-1] ? DW'(-den_in) : DW'(den_in);
    for (int k = 0; k < 3; k++) begin
      n_abs[k] = num_in[k][NUW-1] ? NUW'(-num_in[k]) : NUW'(num_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QB-1:0], in_valid};
    end
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (en) begin
      dd_st[0]       <= dd_abs;
      a_st[0]        <= a_in;
      f_st[0].degen  <= (den_in == '0);
      for (int k = 0; k < 3; k++) begin
        r_st[0][k]       <= n_abs[k];
        q_st[0][k]       <= '0;
        f_st[0].neg[k]   <= num_in[k][NUW-1] ^ den_in[DW-1];
        f_st[0].ovf[k]   <= (XW'(n_abs[k]) >= (XW'(dd_abs) << QB));
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_bit
    localparam int BIT = QB - 1 - s;
    logic [XW-1:0] sh;
    logic [XW-1:0] rx [3];
    logic          ge [3];

    always_comb begin
      sh = XW'(dd_st[s]) << BIT;
      for (int k = 0; k < 3; k++) begin
        rx[k] = XW'(r_st[s][k]);
        ge[k] = (rx[k] >= sh);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd_st[s+1] <= dd_st[s];
        a_st[s+1]  <= a_st[s];
        f_st[s+1]  <= f_st[s];
        for (int k = 0; k < 3; k++) begin
          r_st[s+1][k] <= ge[k] ? NUW'(rx[k] - sh) : r_st[s][k];
          q_st[s+1][k] <= q_st[s][k] | (QB'(ge[k]) << BIT);
        end
      end
    end
  end

  assign out_valid = v[QB];
  assign a_out     = a_st[QB];
  assign q_out     = q_st[QB];
  assign flags_out = f_st[QB];

endmodule

// ===== rtl/core/tetrahedron_circumcenter.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_circumcenter
// circumcenter of a tetrahedron given as four fixed point corners
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries corners a, b, c, d; output channel
// out_valid/out_ready returns center_x/y/z with degenerate and saturated
// one transfer in, one result out, in order
// the pipeline has six front stages, one divider setup stage, one restoring
// divider stage per quotient bit (COORD_WIDTH + 2 of them) and the final sign,
// offset and clamp stage
// throughput is one item per cycle while out_ready is high
// the whole pipeline advances together; when the result register holds an
// untaken result and out_ready is low, every stage holds and in_ready drops
// empty stages hold as well, so bubbles stay in place during a stall
// reset clears all valid bits; no clearing pass is needed
// a zero determinant gives a zero center with degenerate set
// ----------------------------------------------------------------------------
module tetrahedron_circumcenter #(
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  input  logic signed [COORD_WIDTH-1:0] dx,
  input  logic signed [COORD_WIDTH-1:0] dy,
  input  logic signed [COORD_WIDTH-1:0] dz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH-1:0] center_z,
  output logic                          degenerate,
  output logic                          saturated
);
  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int NUW = 4 * EW + 4;
  localparam int DW  = 3 * EW + 4;
  localparam int QB  = W + 2;
  localparam int SW  = QB + 2;
  localparam logic signed [SW-1:0] HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic                 en;
  logic signed [W-1:0]  a_in [3];
  logic signed [W-1:0]  p_in [3][3];

  logic                 g_valid;
  logic signed [W-1:0]  g_a [3];
  logic signed [NUW-1:0] g_num [3];
  logic signed [DW-1:0] g_den;

  logic                 d_valid;
  logic signed [W-1:0]  d_a [3];
  logic [QB-1:0]        d_q [3];
  tcc_pkg::tcc_flags_t  d_flags;

  logic signed [QB:0]   qs [3];
  logic signed [SW-1:0] sum [3];
  logic signed [W-1:0]  res [3];
  logic [2:0]           clamp;

  logic                 out_valid_r;
  logic signed [W-1:0]  center [3];
  logic                 degen_r;
  logic                 sat_r;

  // one enable for the whole pipe: moves when the result register is free
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  assign a_in = '{ax, ay, az};
  assign p_in = '{'{bx, by_coord, bz}, '{cx, cy, cz}, '{dx, dy, dz}};

  tcc_geom #(.W(W)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a_in      (a_in),
    .p_in      (p_in),
    .out_valid (g_valid),
    .a_out     (g_a),
    .num_out   (g_num),
    .den_out   (g_den)
  );

  tcc_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .a_in      (g_a),
    .num_in    (g_num),
    .den_in    (g_den),
    .out_valid (d_valid),
    .a_out     (d_a),
    .q_out     (d_q),
    .flags_out (d_flags)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k]  = d_flags.neg[k] ? -$signed({1'b0, d_q[k]}) : $signed({1'b0, d_q[k]});
      sum[k] = SW'(qs[k]) + SW'(d_a[k]);
      clamp[k] = 1'b0;
      res[k]   = W'(sum[k]);
      if (d_flags.ovf[k]) begin
        clamp[k] = 1'b1;
        res[k]   = d_flags.neg[k] ? W'(LO) : W'(HI);
      end else if (sum[k] > HI) begin
        clamp[k] = 1'b1;
        res[k]   = W'(HI);
      end else if (sum[k] < LO) begin
        clamp[k] = 1'b1;
        res[k]   = W'(LO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen_r <= d_flags.degen;
      if (d_flags.degen) begin
        center <= '{'0, '0, '0};
        sat_r  <= 1'b0;
      end else begin
        center <= res;
        sat_r  <= |clamp;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign center_x   = center[0];
  assign center_y   = center[1];
  assign center_z   = center[2];
  assign degenerate = degen_r;
  assign saturated  = sat_r;

endmodule

// ===== rtl/core/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// tcc_checker
// port level checks of the tetrahedron circumcenter, bound to the top level
// ----------------------------------------------------------------------------
`include "tetrahedron_circumcenter_assert.svh"

module tcc_checker #(
  parameter int W = tcc_pkg::COORD_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [W-1:0]  center_x,
  input logic signed [W-1:0]  center_y,
  input logic signed [W-1:0]  center_z,
  input logic                 degenerate,
  input logic                 saturated
);

  // stalled result holds: out_valid, center_x and degenerate stay stable
  `TCC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(center_x) && $stable(degenerate), "output changed while stalled")

  // input side only blocked by an untaken result
  `TCC_ASSERT(a_ready_link, in_ready == (out_ready || !out_valid), "in_ready does not follow the output stage")

  // degenerate tetrahedron gives zero center and no clamp
  `TCC_ASSERT(a_degen_zero, out_valid && degenerate |-> center_x == '0 && center_y == '0 && center_z == '0 && !saturated, "degenerate result not zero")

  // nothing is offered right after reset
  `TCC_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result offered after reset")

endmodule

bind tetrahedron_circumcenter tcc_checker #(.W(COORD_WIDTH)) u_tcc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .center_x   (center_x),
  .center_y   (center_y),
  .center_z   (center_z),
  .degenerate (degenerate),
  .saturated  (saturated)
);
